// ===== rtl/dual_supply_self_test_sequencer_top_assert.svh =====
// Assertion macros used by the checker module of the self-test sequencer.
`ifndef DUAL_SUPPLY_SELF_TEST_SEQUENCER_TOP_ASSERT_SVH
`define DUAL_SUPPLY_SELF_TEST_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSST_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, disabled during reset.
`define DSST_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/dsst_pkg.sv =====
// Types, codes and reset values shared by the self-test sequencer modules.
package dsst_pkg;

    localparam logic KIND_POLL    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEST_VOLTAGE  = 3'd0,
        REG_TEST_CURRENT  = 3'd1,
        REG_VOLTAGE_TOL   = 3'd2,
        REG_SETTLE        = 3'd3,
        REG_TIMEOUT       = 3'd4
    } reg_index_t;

    localparam logic [15:0] TEST_VOLTAGE_RESET = 16'd12000;
    localparam logic [13:0] TEST_CURRENT_RESET = 14'd1000;
    localparam logic [15:0] VOLTAGE_TOL_RESET  = 16'd500;
    localparam logic [15:0] SETTLE_RESET       = 16'd1000;
    localparam logic [15:0] TIMEOUT_RESET      = 16'd5000;

    typedef enum logic [2:0] {
        PH_START       = 3'd0,
        PH_WAIT_WRITES = 3'd1,
        PH_CHECK       = 3'd2,
        PH_ENABLE0     = 3'd3,
        PH_VERIFY0     = 3'd4,
        PH_ENABLE1     = 3'd5,
        PH_VERIFY1     = 3'd6,
        PH_COMPLETE    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_PASS = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CAUSE_NONE       = 3'd0,
        CAUSE_OFFLINE    = 3'd1,
        CAUSE_VOLTAGE    = 3'd2,
        CAUSE_OUTPUT0    = 3'd3,
        CAUSE_OUTPUT1    = 3'd4,
        CAUSE_INCOMPLETE = 3'd5
    } cause_t;

    typedef struct packed {
        logic [15:0] test_voltage_mv;
        logic [13:0] test_current_ma;
        logic [15:0] voltage_tolerance_mv;
        logic [15:0] settle_ms;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        ch0_writes_pending;
        logic        ch1_writes_pending;
        logic        both_connected;
        logic [15:0] ch0_set_voltage_mv;
        logic [15:0] ch1_set_voltage_mv;
        logic        ch0_output_on;
        logic        ch1_output_on;
    } in_item_t;

    typedef struct packed {
        logic    disable_ch1;
        logic    enable_ch1;
        logic    disable_ch0;
        logic    enable_ch0;
        logic    write_test_setpoints;
        cause_t  fail_cause;
        status_t test_status;
    } result_t;

endpackage

// ===== rtl/dual_supply_self_test_sequencer_top.sv =====
// Top level of the dual supply self-test sequencer.
//
//   Channel   Direction  Handshake              Payload
//   s_*       in         s_tvalid / s_tready    s_tdata (poll fields), s_tuser (kind)
//   m_*       out        m_tvalid / m_tready    m_tdata (status, cause, commands)
//   cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction is taken per cycle while the output does not stall, and its result
// is offered on the output once it has passed the input and output registers.
// The input register feeds the phase logic, whose result lands in the output register.
// A stall on the output holds the output register and a full input register; the input side keeps taking a
// transaction while the output register drains in the same cycle.
// Reset returns the test to its start phase and the configuration registers to their defaults.
module dual_supply_self_test_sequencer_top
    import dsst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_ms[31:0], ch0_writes_pending[32], ch1_writes_pending[33],
    // both_connected[34], ch0_set_voltage_mv[50:35], ch1_set_voltage_mv[66:51],
    // ch0_output_on[67], ch1_output_on[68], zero[71:69]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // test_status[1:0], fail_cause[4:2], write_test_setpoints[5], enable_ch0[6],
    // disable_ch0[7], enable_ch1[8], disable_ch1[9], zero[15:10]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg;
    in_item_t in_item;
    in_item_t in_item_reg;
    logic     in_valid_reg;
    logic     in_valid_next;
    result_t  result;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     advance;
    logic     fire;

    assign in_item.kind               = s_tuser;
    assign in_item.now_ms             = s_tdata[31:0];
    assign in_item.ch0_writes_pending = s_tdata[32];
    assign in_item.ch1_writes_pending = s_tdata[33];
    assign in_item.both_connected     = s_tdata[34];
    assign in_item.ch0_set_voltage_mv = s_tdata[50:35];
    assign in_item.ch1_set_voltage_mv = s_tdata[66:51];
    assign in_item.ch0_output_on      = s_tdata[67];
    assign in_item.ch1_output_on      = s_tdata[68];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    dsst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsst_seq_core u_seq_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .fire   (fire),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

// ===== rtl/dsst_cfg_regs.sv =====
// Configuration register bank of the self-test sequencer.
module dsst_cfg_regs
    import dsst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEST_VOLTAGE: cfg_next.test_voltage_mv      = cfg_data;
                REG_TEST_CURRENT: cfg_next.test_current_ma      = cfg_data[13:0];
                REG_VOLTAGE_TOL:  cfg_next.voltage_tolerance_mv = cfg_data;
                REG_SETTLE:       cfg_next.settle_ms            = cfg_data;
                REG_TIMEOUT:      cfg_next.timeout_ms           = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.test_voltage_mv      <= TEST_VOLTAGE_RESET;
            cfg_reg.test_current_ma      <= TEST_CURRENT_RESET;
            cfg_reg.voltage_tolerance_mv <= VOLTAGE_TOL_RESET;
            cfg_reg.settle_ms            <= SETTLE_RESET;
            cfg_reg.timeout_ms           <= TIMEOUT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/dsst_seq_core.sv =====
// Phase state machine of the self-test sequencer with its result logic.
module dsst_seq_core
    import dsst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  in_item_t item,
    input  logic     fire,
    output result_t  result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [1:0]  passed_reg;
    logic [1:0]  passed_next;

    logic [31:0] elapsed;
    logic        settled;
    logic        timed_out;
    logic [16:0] diff0;
    logic [16:0] diff1;
    logic        volt0_ok;
    logic        volt1_ok;
    logic        restart;

    assign restart   = (item.kind == KIND_RESTART);
    assign elapsed   = item.now_ms - start_reg;
    assign settled   = elapsed >= {16'd0, cfg.settle_ms};
    assign timed_out = elapsed > {16'd0, cfg.timeout_ms};

    assign diff0 = {1'b0, item.ch0_set_voltage_mv} - {1'b0, cfg.test_voltage_mv};
    assign diff1 = {1'b0, item.ch1_set_voltage_mv} - {1'b0, cfg.test_voltage_mv};
    assign volt0_ok = diff0[16] ? ((~diff0[15:0] + 16'd1) <= cfg.voltage_tolerance_mv)
                                : (diff0[15:0] <= cfg.voltage_tolerance_mv);
    assign volt1_ok = diff1[16] ? ((~diff1[15:0] + 16'd1) <= cfg.voltage_tolerance_mv)
                                : (diff1[15:0] <= cfg.voltage_tolerance_mv);

    always_comb
    begin
        phase_next  = phase_reg;
        start_next  = start_reg;
        passed_next = passed_reg;
        if (restart)
        begin
            phase_next  = PH_START;
            start_next  = 32'd0;
            passed_next = 2'b00;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    phase_next = PH_WAIT_WRITES;
                    start_next = item.now_ms;
                end
                PH_WAIT_WRITES:
                begin
                    if (!item.ch0_writes_pending && !item.ch1_writes_pending)
                    begin
                        phase_next = PH_CHECK;
                        start_next = item.now_ms;
                    end
                end
                PH_CHECK:
                begin
                    if (settled && item.both_connected && volt0_ok && volt1_ok)
                    begin
                        phase_next = PH_ENABLE0;
                        start_next = item.now_ms;
                    end
                end
                PH_ENABLE0:
                begin
                    phase_next = PH_VERIFY0;
                    start_next = item.now_ms;
                end
                PH_VERIFY0:
                begin
                    if (settled && item.ch0_output_on)
                    begin
                        passed_next[0] = 1'b1;
                        phase_next     = PH_ENABLE1;
                        start_next     = item.now_ms;
                    end
                end
                PH_ENABLE1:
                begin
                    if (settled)
                    begin
                        phase_next = PH_VERIFY1;
                        start_next = item.now_ms;
                    end
                end
                PH_VERIFY1:
                begin
                    if (settled && item.ch1_output_on)
                    begin
                        passed_next[1] = 1'b1;
                        phase_next     = PH_COMPLETE;
                        start_next     = item.now_ms;
                    end
                end
                PH_COMPLETE:
                begin
                    phase_next = PH_COMPLETE;
                end
            endcase
        end
    end

    always_comb
    begin
        result = '{test_status: ST_BUSY, fail_cause: CAUSE_NONE, default: 1'b0};
        if (!restart)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    result.write_test_setpoints = 1'b1;
                end
                PH_WAIT_WRITES:
                begin
                    result.test_status = ST_BUSY;
                end
                PH_CHECK:
                begin
                    if (settled && !item.both_connected)
                    begin
                        result.test_status = ST_FAIL;
                        result.fail_cause  = CAUSE_OFFLINE;
                    end
                    else if (settled && (!volt0_ok || !volt1_ok))
                    begin
                        result.test_status = ST_FAIL;
                        result.fail_cause  = CAUSE_VOLTAGE;
                    end
                end
                PH_ENABLE0:
                begin
                    result.enable_ch0 = 1'b1;
                end
                PH_VERIFY0:
                begin
                    if (settled && item.ch0_output_on)
                    begin
                        result.disable_ch0 = 1'b1;
                    end
                    else if (settled && timed_out)
                    begin
                        result.test_status = ST_FAIL;
                        result.fail_cause  = CAUSE_OUTPUT0;
                    end
                end
                PH_ENABLE1:
                begin
                    result.enable_ch1 = settled;
                end
                PH_VERIFY1:
                begin
                    if (settled && item.ch1_output_on)
                    begin
                        result.disable_ch1 = 1'b1;
                    end
                    else if (settled && timed_out)
                    begin
                        result.test_status = ST_FAIL;
                        result.fail_cause  = CAUSE_OUTPUT1;
                    end
                end
                PH_COMPLETE:
                begin
                    if (settled && (passed_reg == 2'b11))
                    begin
                        result.test_status = ST_PASS;
                    end
                    else if (settled)
                    begin
                        result.test_status = ST_FAIL;
                        result.fail_cause  = CAUSE_INCOMPLETE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            start_reg  <= 32'd0;
            passed_reg <= 2'b00;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            passed_reg <= passed_next;
        end
    end

endmodule

// ===== rtl/dsst_checker.sv =====
// Port-level checker of the self-test sequencer, bound to the top level.
`include "dual_supply_self_test_sequencer_top_assert.svh"

module dsst_checker
    import dsst_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic result_failed;
    logic cause_given;
    logic command_given;

    assign result_failed = (m_tdata[1:0] == ST_FAIL);
    assign cause_given   = (m_tdata[4:2] != CAUSE_NONE);
    assign command_given = (m_tdata[9:5] != 5'd0);

    `DSST_ASSERT_NEXT(a_valid_held, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `DSST_ASSERT_NEXT(a_data_held, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `DSST_ASSERT_NOW(a_cause_iff_fail, clk, rst_n, m_tvalid, result_failed == cause_given)
    `DSST_ASSERT_NOW(a_one_command, clk, rst_n, m_tvalid, $onehot0(m_tdata[9:5]))
    `DSST_ASSERT_NOW(a_command_busy, clk, rst_n, m_tvalid && command_given, m_tdata[1:0] == ST_BUSY)

endmodule

bind dual_supply_self_test_sequencer_top dsst_checker u_dsst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the dual supply self-test sequencer top level.
module tb
    import dsst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 220;
    localparam int QUIET_ITEMS = 150;
    localparam logic [4:0] CMD_NONE  = 5'b00000;
    localparam logic [4:0] CMD_WRITE = 5'b00001;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_ms;
        logic        ch0_writes_pending;
        logic        ch1_writes_pending;
        logic        both_connected;
        logic [15:0] ch0_set_voltage_mv;
        logic [15:0] ch1_set_voltage_mv;
        logic        ch0_output_on;
        logic        ch1_output_on;
    } poll_t;

    typedef struct {
        poll_t   item;
        bit      typed;
        result_t want;
    } step_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [15:0] cfg_volt    = TEST_VOLTAGE_RESET;
    logic [13:0] cfg_curr    = TEST_CURRENT_RESET;
    logic [15:0] cfg_tol     = VOLTAGE_TOL_RESET;
    logic [15:0] cfg_settle  = SETTLE_RESET;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;

    phase_t      seq_phase   = PH_START;
    logic [31:0] phase_t0_ms = '0;
    logic [1:0]  output_ok   = '0;
    logic [31:0] last_ms     = '0;

    result_t     expected_results[$];
    step_row_t   directed_steps[$];
    int          mismatches  = 0;
    int          hold_off_len = 0;
    bit          quiet = 1'b0;

    dual_supply_self_test_sequencer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("dual_supply_self_test_sequencer_top: mismatch");
        $finish;
    end

    function automatic result_t verdict(status_t st, cause_t ca, logic [4:0] cmds);
        result_t r;
        r.test_status = st;
        r.fail_cause  = ca;
        {r.disable_ch1, r.enable_ch1, r.disable_ch0, r.enable_ch0,
         r.write_test_setpoints} = cmds;
        return r;
    endfunction

    function automatic bit near_test_voltage(logic [15:0] v);
        logic [15:0] d;
        d = (v > cfg_volt) ? v - cfg_volt : cfg_volt - v;
        return d <= cfg_tol;
    endfunction

    function automatic void enter_phase(phase_t ph, logic [31:0] now);
        seq_phase   = ph;
        phase_t0_ms = now;
    endfunction

    function automatic result_t advance_test(poll_t p);
        result_t     r;
        logic [31:0] elapsed;
        logic        settled;
        logic        overdue;
        r       = verdict(ST_BUSY, CAUSE_NONE, CMD_NONE);
        elapsed = p.now_ms - phase_t0_ms;
        settled = elapsed >= {16'd0, cfg_settle};
        overdue = elapsed > {16'd0, cfg_timeout};
        if (p.kind == KIND_RESTART)
        begin
            seq_phase   = PH_START;
            phase_t0_ms = '0;
            output_ok   = '0;
        end
        else
        begin
            case (seq_phase)
                PH_START:
                begin
                    r.write_test_setpoints = 1'b1;
                    enter_phase(PH_WAIT_WRITES, p.now_ms);
                end
                PH_WAIT_WRITES:
                    if (!p.ch0_writes_pending && !p.ch1_writes_pending)
                        enter_phase(PH_CHECK, p.now_ms);
                PH_CHECK:
                    if (settled)
                    begin
                        if (!p.both_connected)
                            r = verdict(ST_FAIL, CAUSE_OFFLINE, CMD_NONE);
                        else if (!near_test_voltage(p.ch0_set_voltage_mv) ||
                                 !near_test_voltage(p.ch1_set_voltage_mv))
                            r = verdict(ST_FAIL, CAUSE_VOLTAGE, CMD_NONE);
                        else
                            enter_phase(PH_ENABLE0, p.now_ms);
                    end
                PH_ENABLE0:
                begin
                    r.enable_ch0 = 1'b1;
                    enter_phase(PH_VERIFY0, p.now_ms);
                end
                PH_VERIFY0:
                    if (settled)
                    begin
                        if (p.ch0_output_on)
                        begin
                            output_ok[0]  = 1'b1;
                            r.disable_ch0 = 1'b1;
                            enter_phase(PH_ENABLE1, p.now_ms);
                        end
                        else if (overdue)
                            r = verdict(ST_FAIL, CAUSE_OUTPUT0, CMD_NONE);
                    end
                PH_ENABLE1:
                    if (settled)
                    begin
                        r.enable_ch1 = 1'b1;
                        enter_phase(PH_VERIFY1, p.now_ms);
                    end
                PH_VERIFY1:
                    if (settled)
                    begin
                        if (p.ch1_output_on)
                        begin
                            output_ok[1]  = 1'b1;
                            r.disable_ch1 = 1'b1;
                            enter_phase(PH_COMPLETE, p.now_ms);
                        end
                        else if (overdue)
                            r = verdict(ST_FAIL, CAUSE_OUTPUT1, CMD_NONE);
                    end
                default:
                    if (settled)
                        r = (&output_ok) ? verdict(ST_PASS, CAUSE_NONE, CMD_NONE)
                                         : verdict(ST_FAIL, CAUSE_INCOMPLETE, CMD_NONE);
            endcase
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_voltage();
        int off;
        int val;
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom());
        off = $urandom_range(0, int'(cfg_tol) + int'(cfg_tol) / 8 + 1);
        val = ($urandom_range(0, 1) != 0) ? int'(cfg_volt) + off : int'(cfg_volt) - off;
        if (val < 0)
            val = 0;
        else if (val > 65535)
            val = 65535;
        return 16'(val);
    endfunction

    // Most polls move time forward from the last one; some land exactly on the
    // settle and timeout edges of the current phase, on either side, and a few jump anywhere.
    function automatic poll_t random_poll();
        poll_t       p;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        span = int'(cfg_settle);
        if (int'(cfg_timeout) / 2 > span)
            span = int'(cfg_timeout) / 2;
        span = span + span / 2 + 16;
        p.kind = (pick < 4) ? KIND_RESTART : KIND_POLL;
        if (pick < 9)
            p.now_ms = $urandom();
        else if (pick < 22)
            p.now_ms = phase_t0_ms + cfg_settle - 32'($urandom_range(0, 1));
        else if (pick < 30)
            p.now_ms = phase_t0_ms + cfg_timeout + 32'($urandom_range(0, 1));
        else
            p.now_ms = last_ms + $urandom_range(0, span);
        last_ms = p.now_ms;
        p.ch0_writes_pending = ($urandom_range(0, 4) == 0);
        p.ch1_writes_pending = ($urandom_range(0, 4) == 0);
        p.both_connected     = ($urandom_range(0, 9) != 0);
        p.ch0_set_voltage_mv = pick_voltage();
        p.ch1_set_voltage_mv = pick_voltage();
        p.ch0_output_on      = ($urandom_range(0, 3) != 0);
        p.ch1_output_on      = ($urandom_range(0, 3) != 0);
        return p;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [2:0] got, logic [2:0] want);
        if (got !== want)
            flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic add_step(logic k, logic [31:0] t, logic p0, logic p1, logic cn,
                            logic [15:0] va, logic [15:0] vb, logic o0, logic o1,
                            bit typed, result_t want);
        step_row_t row;
        row.item  = '{k, t, p0, p1, cn, va, vb, o0, o1};
        row.typed = typed;
        row.want  = want;
        directed_steps.push_back(row);
    endtask

    task automatic offer(poll_t p, bit typed, result_t want);
        result_t predicted;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.kind;
        s_tdata  <= {3'b000, p.ch1_output_on, p.ch0_output_on, p.ch1_set_voltage_mv,
                     p.ch0_set_voltage_mv, p.both_connected, p.ch1_writes_pending,
                     p.ch0_writes_pending, p.now_ms};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_test(p);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] volt, logic [15:0] curr, logic [15:0] tol,
                                 logic [15:0] settle, logic [15:0] tmo);
        reg_index_t  regs[5] = '{REG_TEST_VOLTAGE, REG_TEST_CURRENT, REG_VOLTAGE_TOL,
                                 REG_SETTLE, REG_TIMEOUT};
        logic [15:0] vals[5];
        vals = '{volt, curr, tol, settle, tmo};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (regs[i])
                REG_TEST_VOLTAGE: cfg_volt    = vals[i];
                REG_TEST_CURRENT: cfg_curr    = vals[i][13:0];
                REG_VOLTAGE_TOL:  cfg_tol     = vals[i];
                REG_SETTLE:       cfg_settle  = vals[i];
                default:          cfg_timeout = vals[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                flag_error($sformatf("result %h arrived with nothing expected", m_tdata));
            else
            begin
                want = expected_results.pop_front();
                check_field("test_status", 3'(m_tdata[1:0]), 3'(want.test_status));
                check_field("fail_cause", m_tdata[4:2], want.fail_cause);
                check_field("write_test_setpoints", 3'(m_tdata[5]),
                            3'(want.write_test_setpoints));
                check_field("enable_ch0", 3'(m_tdata[6]), 3'(want.enable_ch0));
                check_field("disable_ch0", 3'(m_tdata[7]), 3'(want.disable_ch0));
                check_field("enable_ch1", 3'(m_tdata[8]), 3'(want.enable_ch1));
                check_field("disable_ch1", 3'(m_tdata[9]), 3'(want.disable_ch1));
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        result_t any;
        int      sent;
        any = verdict(ST_BUSY, CAUSE_NONE, CMD_NONE);
        sent = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_POLL;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TEST_VOLTAGE;
        cfg_data  <= '0;

        // Default settings: 12 V test voltage, 500 mV tolerance, 1 s settle, 5 s timeout.
        add_step(KIND_POLL, 32'd0, 0, 0, 1, 16'd12000, 16'd12000, 0, 0,
                 1, verdict(ST_BUSY, CAUSE_NONE, CMD_WRITE));
        add_step(KIND_POLL, 32'd5, 1, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd10, 0, 1, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd20, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd1019, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd1020, 0, 0, 0, 16'd12000, 16'd0, 0, 0,
                 1, verdict(ST_FAIL, CAUSE_OFFLINE, CMD_NONE));
        add_step(KIND_POLL, 32'd1021, 0, 0, 1, 16'hFFFF, 16'd12000, 0, 0,
                 1, verdict(ST_FAIL, CAUSE_VOLTAGE, CMD_NONE));
        add_step(KIND_POLL, 32'd1022, 0, 0, 1, 16'd12500, 16'd11500, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd1023, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd2022, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd6023, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd6024, 0, 0, 1, 16'd12000, 16'd12000, 0, 0,
                 1, verdict(ST_FAIL, CAUSE_OUTPUT0, CMD_NONE));
        add_step(KIND_POLL, 32'd6025, 0, 0, 1, 16'd12000, 16'd12000, 1, 0, 0, any);
        add_step(KIND_POLL, 32'd7024, 0, 0, 1, 16'd12000, 16'd12000, 1, 0, 0, any);
        add_step(KIND_POLL, 32'd7025, 0, 0, 1, 16'd12000, 16'd12000, 1, 0, 0, any);
        add_step(KIND_POLL, 32'd12026, 0, 0, 1, 16'd12000, 16'd12000, 1, 0,
                 1, verdict(ST_FAIL, CAUSE_OUTPUT1, CMD_NONE));
        add_step(KIND_POLL, 32'd12027, 0, 0, 1, 16'd12000, 16'd12000, 1, 1, 0, any);
        add_step(KIND_POLL, 32'd13027, 0, 0, 1, 16'd12000, 16'd12000, 1, 1,
                 1, verdict(ST_PASS, CAUSE_NONE, CMD_NONE));
        add_step(KIND_POLL, 32'hFFFF_FFFF, 1, 1, 1, 16'hFFFF, 16'hFFFF, 1, 1, 0, any);
        add_step(KIND_RESTART, 32'hFFFF_FFFF, 1, 1, 1, 16'hFFFF, 16'hFFFF, 1, 1,
                 1, verdict(ST_BUSY, CAUSE_NONE, CMD_NONE));
        add_step(KIND_POLL, 32'hFFFF_FFF0, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'hFFFF_FFF8, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd991, 0, 0, 1, 16'd12000, 16'd12000, 0, 0, 0, any);
        add_step(KIND_POLL, 32'd992, 0, 0, 1, 16'd11500, 16'd12500, 0, 0, 0, any);
        add_step(KIND_RESTART, 32'd0, 0, 0, 0, 16'd0, 16'd0, 0, 0,
                 1, verdict(ST_BUSY, CAUSE_NONE, CMD_NONE));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            offer(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 5; ph++)
        begin
            drain_results();
            case (ph)
                0: load_settings(16'($urandom()), 16'($urandom()),
                                 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                                 16'($urandom_range(0, 10000)));
                1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_settings(16'($urandom()), 16'($urandom()),
                                 16'($urandom_range(0, 200)), 16'($urandom_range(0, 50)),
                                 16'($urandom_range(0, 200)));
                default: load_settings(TEST_VOLTAGE_RESET, {2'b11, TEST_CURRENT_RESET},
                                       VOLTAGE_TOL_RESET, SETTLE_RESET, TIMEOUT_RESET);
            endcase
            if (ph == 0)
                hold_off_len = 200;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                quiet = (ph == 4) && (n >= PHASE_ITEMS - QUIET_ITEMS);
                offer(random_poll(), 1'b0, any);
                sent++;
            end
            s_tvalid <= 1'b0;
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("dual_supply_self_test_sequencer_top: match");
        else
            $display("dual_supply_self_test_sequencer_top: mismatch");
        $finish;
    end

endmodule
